@@ hw/rtl/multiplexed_seven_segment_counter_top_macros.svh @@
// Assertion macros for the seven-segment counter checker.
// Included by the checker file only; no other dependencies.
`ifndef MULTIPLEXED_SEVEN_SEGMENT_COUNTER_TOP_MACROS_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_COUNTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define MSSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define MSSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/mssc_pkg.sv @@
// Shared types, register codes and digit helpers for the seven-segment counter.
// No dependencies; imported by the counter, display and top-level modules.
`timescale 1ns / 1ps
`default_nettype none

package mssc_pkg;

   // Configuration register indexes
   localparam logic [1:0] REG_COUNT_MODE = 2'd0;
   localparam logic [1:0] REG_PRESET     = 2'd1;
   localparam logic [1:0] REG_TICKS      = 2'd2;

   // Count modes (code 3 behaves as count up)
   localparam logic [1:0] MODE_UP   = 2'd0;
   localparam logic [1:0] MODE_DOWN = 2'd1;
   localparam logic [1:0] MODE_MMSS = 2'd2;

   localparam logic [7:0]  TICKS_RESET  = 8'd200;
   localparam logic [13:0] PRESET_MAX   = 14'd9999;
   localparam logic [7:0]  SECONDS_WRAP = 8'd60;
   localparam logic [7:0]  PAIR_WRAP    = 8'd100;
   localparam logic [6:0]  PAIR_MAX     = 7'd99;

   // Reciprocal of 100 as 5243 / 2^19, exact for values up to 9999
   localparam logic [12:0] RECIP_100 = 13'd5243;
   // Reciprocal of 10 as 205 / 2^11, exact for values up to 99
   localparam logic [7:0]  RECIP_10  = 8'd205;

   localparam logic [7:0] SEG_BLANK = 8'hFF;

   // Configuration seen by the counter core
   typedef struct packed {
      logic [1:0]  count_mode;
      logic [13:0] preset_value;   // already clamped to 9999
      logic [6:0]  preset_upper;   // preset_value / 100
      logic [7:0]  ticks_per_count;
   } cfg_type;

   // Count after the update of one beat plus the scan position it shows
   typedef struct packed {
      logic [6:0] upper_digits;
      logic [6:0] lower_digits;
      logic       done_flag;
      logic [1:0] scan_position;
   } view_type;

   function automatic logic [3:0] tens_of(input logic [6:0] pair);
      logic [14:0] prod;
      begin
         prod = {8'd0, pair} * {7'd0, RECIP_10};
         return prod[14:11];
      end
   endfunction

   function automatic logic [3:0] units_of(input logic [6:0] pair);
      logic [6:0] tens10;
      logic [6:0] diff;
      begin
         tens10 = {3'd0, tens_of(pair)} * 7'd10;
         diff   = pair - tens10;
         return diff[3:0];
      end
   endfunction

   // Active-low segment pattern, decimal point off
   function automatic logic [7:0] digit_pattern(input logic [3:0] digit);
      logic [7:0] pat;
      begin
         unique case (digit)
            4'd0:    pat = 8'hC0;
            4'd1:    pat = 8'hF9;
            4'd2:    pat = 8'hA4;
            4'd3:    pat = 8'hB0;
            4'd4:    pat = 8'h99;
            4'd5:    pat = 8'h92;
            4'd6:    pat = 8'h82;
            4'd7:    pat = 8'hF8;
            4'd8:    pat = 8'h80;
            4'd9:    pat = 8'h90;
            default: pat = SEG_BLANK;
         endcase
         return pat;
      end
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mssc_counter.sv @@
// Counter core: prescaler, digit pairs, finished flag and scan position.
// Depends on mssc_pkg for cfg_type, view_type and mode codes.
`timescale 1ns / 1ps
`default_nettype none

module mssc_counter
   import mssc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     advance,     // a beat moves to the result register
   input  wire logic     run,
   input  wire logic     start_req,
   input  wire cfg_type  cfg,
   output view_type      view
);

   logic [7:0] prescale_ff, prescale_in;
   logic [6:0] upper_ff, upper_in;
   logic [6:0] lower_ff, lower_in;
   logic [1:0] scan_ff, scan_in;
   logic       done_ff, done_in;

   logic [13:0] upper_x100;
   logic [13:0] preset_rem;
   logic [8:0]  prescale_next;
   logic [8:0]  period;
   logic        count_tick;
   logic [7:0]  lower_inc;
   logic [7:0]  upper_inc;
   logic [7:0]  wrap;
   logic [1:0]  shown_scan;

   // lower preset pair: preset - 100 * upper, done with shifts and adds
   assign upper_x100 = {1'b0, cfg.preset_upper, 6'd0} + {2'b0, cfg.preset_upper, 5'd0}
                     + {5'd0, cfg.preset_upper, 2'd0};
   assign preset_rem = cfg.preset_value - upper_x100;

   // prescaler, zero ticks means 256
   assign prescale_next = {1'b0, prescale_ff} + 9'd1;
   assign period        = (cfg.ticks_per_count == 8'd0) ? 9'd256
                                                        : {1'b0, cfg.ticks_per_count};
   assign count_tick    = (prescale_next >= period);

   assign lower_inc = {1'b0, lower_ff} + 8'd1;
   assign upper_inc = {1'b0, upper_ff} + 8'd1;
   assign wrap      = (cfg.count_mode == MODE_MMSS) ? SECONDS_WRAP : PAIR_WRAP;

   // next count state
   always_comb begin
      prescale_in = prescale_ff;
      upper_in    = upper_ff;
      lower_in    = lower_ff;
      done_in     = done_ff;
      shown_scan  = scan_ff;
      priority if (start_req) begin
         if (cfg.count_mode == MODE_DOWN) begin
            upper_in = cfg.preset_upper;
            lower_in = preset_rem[6:0];
         end else begin
            upper_in = 7'd0;
            lower_in = 7'd0;
         end
         prescale_in = 8'd0;
         done_in     = 1'b0;
         shown_scan  = 2'd0;
      end else if (run && !done_ff) begin
         if (!count_tick) begin
            prescale_in = prescale_next[7:0];
         end else begin
            prescale_in = 8'd0;
            if (cfg.count_mode == MODE_DOWN) begin
               if (lower_ff != 7'd0) begin
                  lower_in = lower_ff - 7'd1;
               end else if (upper_ff != 7'd0) begin
                  lower_in = PAIR_MAX;
                  upper_in = upper_ff - 7'd1;
               end else begin
                  done_in = 1'b1;
               end
            end else begin
               if (lower_inc >= wrap) begin
                  lower_in = 7'd0;
                  upper_in = (upper_inc >= PAIR_WRAP) ? 7'd0 : upper_inc[6:0];
               end else begin
                  lower_in = lower_inc[6:0];
               end
            end
         end
      end
   end

   assign scan_in = shown_scan + 2'd1;

   // state registers, updated once per processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= 8'd0;
         upper_ff    <= 7'd0;
         lower_ff    <= 7'd0;
         scan_ff     <= 2'd0;
         done_ff     <= 1'b0;
      end else if (advance) begin
         prescale_ff <= prescale_in;
         upper_ff    <= upper_in;
         lower_ff    <= lower_in;
         scan_ff     <= scan_in;
         done_ff     <= done_in;
      end
   end

   assign view.upper_digits  = upper_in;
   assign view.lower_digits  = lower_in;
   assign view.done_flag     = done_in;
   assign view.scan_position = shown_scan;

endmodule

`default_nettype wire

@@ hw/rtl/mssc_display.sv @@
// Display decode: picks the scanned digit, maps it to segments and enables.
// Depends on mssc_pkg for view_type and the digit helpers.
`timescale 1ns / 1ps
`default_nettype none

module mssc_display
   import mssc_pkg::*;
(
   input  wire view_type   view,
   output logic [7:0]      segments,
   output logic [3:0]      digit_enables
);

   logic [3:0] digit;

   // digit select and active-low enable per scan position
   always_comb begin
      unique case (view.scan_position)
         2'd0: begin
            digit         = units_of(view.lower_digits);
            digit_enables = 4'b0111;
         end
         2'd1: begin
            digit         = tens_of(view.lower_digits);
            digit_enables = 4'b1011;
         end
         2'd2: begin
            digit         = units_of(view.upper_digits);
            digit_enables = 4'b1101;
         end
         default: begin
            digit         = tens_of(view.upper_digits);
            digit_enables = 4'b1110;
         end
      endcase
   end

   assign segments = digit_pattern(digit);

endmodule

`default_nettype wire

@@ hw/rtl/multiplexed_seven_segment_counter_top.sv @@
// Usage notes:
// Four-digit multiplexed seven-segment counter (stopwatch). Each beat on the
// req_ channel is one scan tick carrying run and start_req; each tick yields
// exactly one beat on the rsp_ channel with the active-low segment pattern,
// the active-low digit enable, both decimal pairs and the finished flag.
// Registers (count mode, preset, ticks per count) are written on the csr_
// channel, always ready; the user must write them only while no tick is in
// flight, and the block itself does not enforce this.
// An accepted beat is held in the input register, and its result is loaded
// into the output register once that register is free; rsp_tvalid then
// rises. Throughput is one beat per cycle while rsp_tready stays high; the
// count update and digit decode sit in one short path between the two
// registers. When rsp_tready is low the result holds in the output register,
// the input register takes one more beat only if it is empty, and req_tready
// then drops until the result is taken.
// Reset (synchronous, active high) empties both registers, clears the count,
// prescaler, scan and finished flag, and sets ticks per count to 200.
// Files: mssc_pkg, mssc_counter, mssc_display.
`timescale 1ns / 1ps
`default_nettype none

module multiplexed_seven_segment_counter_top
   import mssc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input tick stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [0] run, [1] start_req, [7:2] zero
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,    // [7:0] segments, [11:8] digit_enables,
                                          // [18:12] high_pair, [25:19] low_pair,
                                          // [26] finished, [31:27] zero
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [13:0] csr_data
);

   logic        in_valid_ff;
   logic        in_run_ff;
   logic        in_start_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff, rsp_data_in;

   logic [1:0]  mode_ff;
   logic [13:0] preset_ff;
   logic [6:0]  preset_upper_ff;
   logic [7:0]  ticks_ff;

   logic        out_free;
   logic        advance;
   logic        csr_fire;
   logic [13:0] preset_clamped;
   logic [26:0] preset_prod;
   cfg_type     cfg;
   view_type    view;
   logic [7:0]  segments;
   logic [3:0]  digit_enables;

   // register port
   assign csr_ready      = 1'b1;
   assign csr_fire       = csr_valid && csr_ready;
   assign preset_clamped = (csr_data > PRESET_MAX) ? PRESET_MAX : csr_data;
   assign preset_prod    = {13'd0, preset_clamped} * {14'd0, RECIP_100};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_UP;
         preset_ff       <= 14'd0;
         preset_upper_ff <= 7'd0;
         ticks_ff        <= TICKS_RESET;
      end else if (csr_fire) begin
         unique case (csr_index)
            REG_COUNT_MODE: mode_ff <= csr_data[1:0];
            REG_PRESET: begin
               preset_ff       <= preset_clamped;
               preset_upper_ff <= preset_prod[25:19];
            end
            REG_TICKS:      ticks_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign cfg.count_mode      = mode_ff;
   assign cfg.preset_value    = preset_ff;
   assign cfg.preset_upper    = preset_upper_ff;
   assign cfg.ticks_per_count = ticks_ff;

   // handshake: input register drains whenever the output register is free
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_run_ff   <= req_tdata[0];
         in_start_ff <= req_tdata[1];
      end
   end

   mssc_counter u_counter (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .run       (in_run_ff),
      .start_req (in_start_ff),
      .cfg       (cfg),
      .view      (view)
   );

   mssc_display u_display (
      .view          (view),
      .segments      (segments),
      .digit_enables (digit_enables)
   );

   // result register
   assign rsp_data_in = {5'd0, view.done_flag, view.lower_digits, view.upper_digits,
                         digit_enables, segments};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/mssc_checker.sv @@
// Port-level checker for the seven-segment counter, bound to the top level.
// Depends on the assertion macros header; sees the top-level ports only.
`timescale 1ns / 1ps
`default_nettype none
`include "multiplexed_seven_segment_counter_top_macros.svh"

module mssc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   logic       stalled;
   logic [3:0] enables_n;
   logic [6:0] high_pair;
   logic [6:0] low_pair;
   logic       finished;
   logic       pairs_ok;
   logic       done_ok;

   // result fields as packed on rsp_tdata
   assign stalled   = rsp_tvalid && !rsp_tready;
   assign enables_n = ~rsp_tdata[11:8];
   assign high_pair = rsp_tdata[18:12];
   assign low_pair  = rsp_tdata[25:19];
   assign finished  = rsp_tdata[26];
   assign pairs_ok  = (high_pair <= 7'd99) && (low_pair <= 7'd99);
   assign done_ok   = !finished || ((high_pair == 7'd0) && (low_pair == 7'd0));

   // a stalled result beat stays put
   `MSSC_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_tvalid && $stable(rsp_tdata),
      "result beat changed while stalled")

   // exactly one digit driven per beat
   `MSSC_ASSERT_NOW(a_one_digit, clock, reset, rsp_tvalid, $onehot(enables_n),
      "digit enables not one-hot active-low")

   // finished only with the count stopped at 0000, and pairs stay decimal
   `MSSC_ASSERT_NOW(a_count_range, clock, reset, rsp_tvalid, pairs_ok && done_ok,
      "count out of range or finished with nonzero count")

endmodule

bind multiplexed_seven_segment_counter_top mssc_checker u_mssc_checker (.*);

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking bench for the four-digit multiplexed seven-segment counter.
// Drives scan ticks and CSR writes; checks results against a tick model or typed rows.
// Depends on mssc_pkg and multiplexed_seven_segment_counter_top.
`timescale 1ns / 1ps

module testbench;
   import mssc_pkg::*;

   localparam int RANDOM_TICKS = 1750;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int NUM_ROWS     = 32;

   // Mode code the block treats as count up
   localparam logic [1:0] MODE_SPARE = 2'd3;

   // Directed row kinds
   localparam logic [1:0] ROW_TICK  = 2'd0;   // tick checked against the model
   localparam logic [1:0] ROW_CHECK = 2'd1;   // tick with a typed-in result
   localparam logic [1:0] ROW_CSR   = 2'd2;   // register write while idle

   typedef struct packed {
      logic [7:0] segments;
      logic [3:0] enables;
      logic [6:0] high_pair;
      logic [6:0] low_pair;
      logic       finished;
   } display_beat;

   typedef struct packed {
      logic [1:0]  kind;
      logic        run;
      logic        start;
      logic [1:0]  csr_index;
      logic [13:0] csr_data;
      display_beat shown;
   } stim_row;

   localparam display_beat NO_CHECK = '0;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [31:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [13:0] csr_data;

   // Tick model: configuration and count state
   logic [1:0]  mode_q;
   logic [13:0] preset_q;
   logic [7:0]  ticks_q;
   logic [7:0]  prescale_q;
   logic [6:0]  upper_q;
   logic [6:0]  lower_q;
   logic [1:0]  scan_q;
   logic        done_q;

   display_beat pending_displays[$];
   display_beat want;

   int error_count    = 0;
   int cycle_count    = 0;
   int ticks_sent     = 0;
   int beats_checked  = 0;
   int finished_beats = 0;
   int writes_done    = 0;
   int stall_left     = 0;
   bit sender_idle_on   = 1'b0;
   bit receiver_idle_on = 1'b0;

   logic [7:0] seg_rom [0:9] = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
                                 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};

   stim_row directed_rows [NUM_ROWS] = '{
      // after reset: scan walks, count holds at zero
      '{ROW_CHECK, 1'b0, 1'b0, REG_COUNT_MODE, 14'd0, '{8'hC0, 4'b0111, 7'd0, 7'd0, 1'b0}},
      '{ROW_CHECK, 1'b0, 1'b0, REG_COUNT_MODE, 14'd0, '{8'hC0, 4'b1011, 7'd0, 7'd0, 1'b0}},
      '{ROW_CSR,   1'b0, 1'b0, REG_TICKS,      14'd1, NO_CHECK},
      '{ROW_CHECK, 1'b1, 1'b0, REG_COUNT_MODE, 14'd0, '{8'hC0, 4'b1101, 7'd0, 7'd1, 1'b0}},
      // start wins over counting
      '{ROW_CHECK, 1'b1, 1'b1, REG_COUNT_MODE, 14'd0, '{8'hC0, 4'b0111, 7'd0, 7'd0, 1'b0}},
      // count down, preset above range clamps to 9999
      '{ROW_CSR,   1'b0, 1'b0, REG_COUNT_MODE, {12'd0, MODE_DOWN}, NO_CHECK},
      '{ROW_CSR,   1'b0, 1'b0, REG_PRESET,     14'd16383, NO_CHECK},
      '{ROW_CHECK, 1'b1, 1'b1, REG_COUNT_MODE, 14'd0, '{8'h90, 4'b0111, 7'd99, 7'd99, 1'b0}},
      '{ROW_TICK,  1'b1, 1'b0, REG_COUNT_MODE, 14'd0, NO_CHECK},
      '{ROW_TICK,  1'b0, 1'b0, REG_COUNT_MODE, 14'd0, NO_CHECK},
      // down through zero: finished sets and the count stays
      '{ROW_CSR,   1'b0, 1'b0, REG_PRESET,     14'd1, NO_CHECK},
      '{ROW_CHECK, 1'b0, 1'b1, REG_COUNT_MODE, 14'd0, '{8'hF9, 4'b0111, 7'd0, 7'd1, 1'b0}},
      '{ROW_TICK,  1'b1, 1'b0, REG_COUNT_MODE, 14'd0, NO_CHECK},
      '{ROW_CHECK, 1'b1, 1'b0, REG_COUNT_MODE, 14'd0, '{8'hC0, 4'b1101, 7'd0, 7'd0, 1'b1}},
      '{ROW_TICK,  1'b1, 1'b0, REG_COUNT_MODE, 14'd0, NO_CHECK},
      // still frozen after switching to count up
      '{ROW_CSR,   1'b0, 1'b0, REG_COUNT_MODE, {12'd0, MODE_UP}, NO_CHECK},
      '{ROW_CHECK, 1'b1, 1'b0, REG_COUNT_MODE, 14'd0, '{8'hC0, 4'b0111, 7'd0, 7'd0, 1'b1}},
      // minutes:seconds, period lowered below the prescaler
      '{ROW_CSR,   1'b0, 1'b0, REG_COUNT_MODE, {12'd0, MODE_MMSS}, NO_CHECK},
      '{ROW_CSR,   1'b0, 1'b0, REG_TICKS,      14'd255, NO_CHECK},
      '{ROW_TICK,  1'b0, 1'b1, REG_COUNT_MODE, 14'd0, NO_CHECK},
      '{ROW_TICK,  1'b1, 1'b0, REG_COUNT_MODE, 14'd0, NO_CHECK},
      '{ROW_TICK,  1'b1, 1'b0, REG_COUNT_MODE, 14'd0, NO_CHECK},
      '{ROW_TICK,  1'b1, 1'b0, REG_COUNT_MODE, 14'd0, NO_CHECK},
      '{ROW_CSR,   1'b0, 1'b0, REG_TICKS,      14'd2, NO_CHECK},
      '{ROW_TICK,  1'b1, 1'b0, REG_COUNT_MODE, 14'd0, NO_CHECK},
      // zero period means 256 ticks
      '{ROW_CSR,   1'b0, 1'b0, REG_TICKS,      14'd0, NO_CHECK},
      '{ROW_TICK,  1'b1, 1'b0, REG_COUNT_MODE, 14'd0, NO_CHECK},
      // spare mode code counts up
      '{ROW_CSR,   1'b0, 1'b0, REG_COUNT_MODE, {12'd0, MODE_SPARE}, NO_CHECK},
      '{ROW_CSR,   1'b0, 1'b0, REG_TICKS,      14'd1, NO_CHECK},
      '{ROW_TICK,  1'b1, 1'b1, REG_COUNT_MODE, 14'd0, NO_CHECK},
      '{ROW_TICK,  1'b1, 1'b0, REG_COUNT_MODE, 14'd0, NO_CHECK},
      '{ROW_TICK,  1'b1, 1'b0, REG_COUNT_MODE, 14'd0, NO_CHECK}
   };

   multiplexed_seven_segment_counter_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // Run-away guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d results pending", cycle_count,
                pending_displays.size());
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Result-side backpressure in random bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (receiver_idle_on && $urandom_range(0, 99) < 12) begin
         stall_left <= $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each result beat with the oldest expected display
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_displays.size() == 0) begin
            $error("result beat %h with no tick pending", rsp_tdata);
            error_count++;
         end else begin
            want = pending_displays.pop_front();
            beats_checked++;
            if (rsp_tdata[26]) finished_beats++;
            if (rsp_tdata[7:0] !== want.segments) begin
               $error("segments: expected %h, actual %h", want.segments, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tdata[11:8] !== want.enables) begin
               $error("digit_enables: expected %b, actual %b", want.enables,
                      rsp_tdata[11:8]);
               error_count++;
            end
            if (rsp_tdata[18:12] !== want.high_pair) begin
               $error("high_pair: expected %0d, actual %0d", want.high_pair,
                      rsp_tdata[18:12]);
               error_count++;
            end
            if (rsp_tdata[25:19] !== want.low_pair) begin
               $error("low_pair: expected %0d, actual %0d", want.low_pair,
                      rsp_tdata[25:19]);
               error_count++;
            end
            if (rsp_tdata[26] !== want.finished) begin
               $error("finished: expected %b, actual %b", want.finished, rsp_tdata[26]);
               error_count++;
            end
            if (rsp_tdata[31:27] !== 5'd0) begin
               $error("pad: expected 0, actual %h", rsp_tdata[31:27]);
               error_count++;
            end
         end
      end
   end

   // One scan tick: reload or count update, show the scanned digit, move the scan on
   function automatic display_beat predict_tick(input logic run, input logic start);
      logic [13:0] clamped;
      logic [8:0]  period;
      logic [8:0]  next;
      logic [6:0]  wrap;
      logic [3:0]  digit;
      display_beat d;
      if (start) begin
         if (mode_q == MODE_DOWN) begin
            clamped = (preset_q > PRESET_MAX) ? PRESET_MAX : preset_q;
            upper_q = 7'(clamped / 14'd100);
            lower_q = 7'(clamped % 14'd100);
         end else begin
            upper_q = '0;
            lower_q = '0;
         end
         prescale_q = '0;
         scan_q     = '0;
         done_q     = 1'b0;
      end else if (run && !done_q) begin
         period = (ticks_q == 8'd0) ? 9'd256 : {1'b0, ticks_q};
         next   = {1'b0, prescale_q} + 9'd1;
         if (next >= period) begin
            prescale_q = '0;
            if (mode_q == MODE_DOWN) begin
               if (lower_q == 7'd0) begin
                  if (upper_q == 7'd0) begin
                     done_q = 1'b1;
                  end else begin
                     lower_q = PAIR_MAX;
                     upper_q = upper_q - 7'd1;
                  end
               end else begin
                  lower_q = lower_q - 7'd1;
               end
            end else begin
               wrap    = (mode_q == MODE_MMSS) ? SECONDS_WRAP[6:0] : PAIR_WRAP[6:0];
               lower_q = lower_q + 7'd1;
               if (lower_q >= wrap) begin
                  lower_q = '0;
                  upper_q = upper_q + 7'd1;
                  if (upper_q >= PAIR_WRAP[6:0]) upper_q = '0;
               end
            end
         end else begin
            prescale_q = next[7:0];
         end
      end
      case (scan_q)
         2'd0:    digit = 4'(lower_q % 7'd10);
         2'd1:    digit = 4'(lower_q / 7'd10);
         2'd2:    digit = 4'(upper_q % 7'd10);
         default: digit = 4'(upper_q / 7'd10);
      endcase
      d.segments  = (digit > 4'd9) ? SEG_BLANK : seg_rom[digit];
      d.enables   = ~(4'b0001 << (2'd3 - scan_q));
      d.high_pair = upper_q;
      d.low_pair  = lower_q;
      d.finished  = done_q;
      scan_q      = scan_q + 2'd1;
      return d;
   endfunction

   // Offer one tick beat, possibly after a gap, and log its expected display
   task automatic send_tick(input logic run, input logic start, input logic typed,
                            input display_beat shown);
      display_beat d;
      @(negedge clock);
      if (sender_idle_on && $urandom_range(0, 99) < 10) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, start, run};
      do @(posedge clock); while (!req_tready);
      d = predict_tick(run, start);
      pending_displays.push_back(typed ? shown : d);
      ticks_sent++;
   endtask

   // Hold off ticks until every expected result has come back
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_displays.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [13:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         REG_COUNT_MODE: mode_q   = value[1:0];
         REG_PRESET:     preset_q = value;
         REG_TICKS:      ticks_q  = value[7:0];
         default: ;
      endcase
      writes_done++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int          base;
      int          beats;
      bit          quiet;
      logic [13:0] preset;
      logic [7:0]  period;
      logic [1:0]  load_mode;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = REG_COUNT_MODE;
      csr_data   = '0;
      mode_q     = MODE_UP;
      preset_q   = '0;
      ticks_q    = TICKS_RESET;
      prescale_q = '0;
      upper_q    = '0;
      lower_q    = '0;
      scan_q     = '0;
      done_q     = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table
      sender_idle_on   = 1'b1;
      receiver_idle_on = 1'b1;
      for (int r = 0; r < NUM_ROWS; r++) begin
         case (directed_rows[r].kind)
            ROW_CSR: begin
               wait_idle();
               write_reg(directed_rows[r].csr_index, directed_rows[r].csr_data);
            end
            ROW_CHECK: send_tick(directed_rows[r].run, directed_rows[r].start, 1'b1,
                                 directed_rows[r].shown);
            default:   send_tick(directed_rows[r].run, directed_rows[r].start, 1'b0,
                                 NO_CHECK);
         endcase
      end

      // Random phases: load a count (often via count down), maybe switch mode, then run
      base = ticks_sent;
      while (ticks_sent - base < RANDOM_TICKS) begin
         quiet            = (ticks_sent - base) > (RANDOM_TICKS * 85 / 100);
         sender_idle_on   = !quiet && ($urandom_range(0, 3) != 0);
         receiver_idle_on = !quiet && ($urandom_range(0, 3) != 0);
         wait_idle();
         case ($urandom_range(0, 5))
            0:       preset = 14'($urandom_range(0, 3));
            1:       preset = PRESET_MAX;
            2:       preset = 14'($urandom_range(10000, 16383));
            3:       preset = 14'($urandom_range(9990, 9999));
            4:       preset = 14'($urandom_range(0, 99) * 100 + $urandom_range(55, 59));
            default: preset = 14'($urandom_range(0, 9999));
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3: period = 8'd1;
            4, 5:       period = 8'($urandom_range(2, 5));
            6:          period = 8'd0;
            7:          period = 8'd255;
            default:    period = 8'($urandom_range(1, 255));
         endcase
         load_mode = ($urandom_range(0, 4) < 3) ? MODE_DOWN : 2'($urandom_range(0, 3));
         write_reg(REG_PRESET, preset);
         write_reg(REG_TICKS, {6'd0, period});
         write_reg(REG_COUNT_MODE, {12'd0, load_mode});
         send_tick(1'($urandom_range(0, 1)), 1'b1, 1'b0, NO_CHECK);
         if ($urandom_range(0, 1) != 0) begin
            wait_idle();
            write_reg(REG_COUNT_MODE, {12'd0, 2'($urandom_range(0, 3))});
         end
         if ((period == 8'd0 || period >= 8'd100) && $urandom_range(0, 2) == 0)
            beats = 300;
         else
            beats = $urandom_range(20, 80);
         for (int i = 0; i < beats; i++) begin
            // sometimes drop the period under the running prescaler mid-phase
            if (i == beats / 2 && $urandom_range(0, 4) == 0) begin
               wait_idle();
               write_reg(REG_TICKS, {6'd0, 8'($urandom_range(1, 3))});
            end
            send_tick($urandom_range(0, 99) < 85, $urandom_range(0, 99) < 2, 1'b0,
                      NO_CHECK);
         end
      end

      // Drain and report
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      wait_idle();
      repeat (4) @(posedge clock);
      $display("Sent %0d scan ticks (%0d random) with %0d register writes;", ticks_sent,
               ticks_sent - base, writes_done);
      $display("checked %0d result beats, %0d of them with finished set.", beats_checked,
               finished_beats);
      if (error_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
